// ===== src/lzoa_pkg.sv =====
// Shared types and constants for the lidar zone obstacle avoider.
// No dependencies; imported by the top level and its port checker.
`timescale 1ns / 1ps

package lzoa_pkg;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_POINT = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_DONE  = 2'd2,
        ACT_STEP  = 2'd3
    } action_t;

    // Drive commands
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_FORWARD = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_LEFT    = 3'd3,
        CMD_RIGHT   = 3'd4,
        CMD_REVERSE = 3'd5
    } cmd_t;

    // Avoidance state
    typedef enum logic [2:0] {
        MODE_FWD    = 3'd0,
        MODE_DECIDE = 3'd1,
        MODE_LEFT   = 3'd2,
        MODE_RIGHT  = 3'd3,
        MODE_REV    = 3'd4
    } mode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] MIN_DIST_RST = 16'd100;
    localparam logic [CFG_DATA_W-1:0] MAX_DIST_RST = 16'd400;
    localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST  = 16'd300;

    // Sector indexes
    localparam int SEC_FRONT = 0;
    localparam int SEC_LEFT  = 1;
    localparam int SEC_BACK  = 2;
    localparam int SEC_RIGHT = 3;
    localparam int NUM_SEC   = 4;

    // Sector bounds in tenths of a degree, all open intervals
    localparam logic [11:0] FRONT_HI = 12'd3450;
    localparam logic [11:0] FRONT_LO = 12'd150;
    localparam logic [11:0] LEFT_LO  = 12'd750;
    localparam logic [11:0] LEFT_HI  = 12'd1050;
    localparam logic [11:0] BACK_LO  = 12'd1650;
    localparam logic [11:0] BACK_HI  = 12'd1950;
    localparam logic [11:0] RIGHT_LO = 12'd2550;
    localparam logic [11:0] RIGHT_HI = 12'd2850;

endpackage

// ===== src/lidar_zone_obstacle_avoider.sv =====
// Lidar zone obstacle avoider: sector flags, expiry timer and avoidance FSM.
// Depends on lzoa_pkg.
`timescale 1ns / 1ps

// Every accepted item (lidar point, millisecond tick, drive done or control
// step) yields exactly one result transfer, registered at acceptance, from
// a single output register. The block takes one item per cycle: s_tready is
// high whenever the output register is empty or its transfer completes in the
// same cycle, so throughput is set by the output register alone and drops
// only while the downstream side holds m_tready low. Each item first ages the
// four sector flags against timeout_ms (a tick advances the millisecond count
// before that), then applies its own effect. Points inside the distance
// window [min_distance_mm, max_distance_mm] mark the front, left, back or
// right sector; control steps run the forward / decide / turn / reverse state
// machine and report the command on the result. Configuration writes are
// accepted in every cycle and should only be issued while the block is idle.
// Register indexes: 0 min distance, 1 max distance, 2 timeout; index 3 is
// ignored.
module lidar_zone_obstacle_avoider (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: angle_tenths[11:0], distance_mm[27:12], radar_hit[28], zero pad
    input  logic [lzoa_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: action[1:0]
    input  logic [lzoa_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: command[2:0], nav_state[5:3], front_blocked[6], left_blocked[7],
    //        right_blocked[8], back_blocked[9], zero pad
    output logic [lzoa_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lzoa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lzoa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import lzoa_pkg::*;

    // Configuration registers
    logic [15:0] min_dist_reg;
    logic [15:0] max_dist_reg;
    logic [15:0] timeout_reg;

    // Tracking state
    logic [31:0]        now_reg,       now_next;
    logic [31:0]        last_seen_reg  [NUM_SEC];
    logic [31:0]        last_seen_next [NUM_SEC];
    logic [NUM_SEC-1:0] flags_reg,     flags_next;
    logic [NUM_SEC-1:0] flags_aged;
    mode_t              mode_reg,      mode_next;
    logic               awaiting_reg,  awaiting_next;
    logic               done_reg,      done_next;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Decoded input fields
    action_t     action;
    logic [11:0] angle;
    logic [15:0] dist_mm;
    logic        radar;
    logic        in_xfer;
    logic        in_window;
    cmd_t        cmd;
    cmd_t        man_cmd;
    mode_t       man_ret;

    assign action  = action_t'(s_tuser);
    assign angle   = s_tdata[11:0];
    assign dist_mm = s_tdata[27:12];
    assign radar   = s_tdata[28];

    // Accept while the output register is free or draining this cycle
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_window = (dist_mm >= min_dist_reg) && (dist_mm <= max_dist_reg);

    // Command and follow-on state of the current manoeuvre
    always_comb begin
        unique case (mode_reg)
            MODE_LEFT: begin
                man_cmd = CMD_LEFT;
                man_ret = MODE_FWD;
            end
            MODE_RIGHT: begin
                man_cmd = CMD_RIGHT;
                man_ret = MODE_FWD;
            end
            default: begin
                man_cmd = CMD_REVERSE;
                man_ret = MODE_DECIDE;
            end
        endcase
    end

    // Next state and result for the item on the input
    always_comb begin
        // A tick advances the ms count before expiry is applied
        now_next = (action == ACT_TICK) ? now_reg + 32'd1 : now_reg;

        // Age every sector against the timeout
        for (int i = 0; i < NUM_SEC; i++) begin
            flags_aged[i] = flags_reg[i] &&
                            !((now_next - last_seen_reg[i]) > {16'd0, timeout_reg});
        end

        flags_next    = flags_aged;
        mode_next     = mode_reg;
        awaiting_next = awaiting_reg;
        done_next     = done_reg;
        cmd           = CMD_NONE;
        for (int i = 0; i < NUM_SEC; i++) begin
            last_seen_next[i] = last_seen_reg[i];
        end

        unique case (action)
            ACT_POINT: begin
                // Sector priority: front, left, back, right
                if (in_window) begin
                    priority if (angle > FRONT_HI || angle < FRONT_LO) begin
                        flags_next[SEC_FRONT]     = 1'b1;
                        last_seen_next[SEC_FRONT] = now_next;
                    end else if (angle > LEFT_LO && angle < LEFT_HI) begin
                        flags_next[SEC_LEFT]      = 1'b1;
                        last_seen_next[SEC_LEFT]  = now_next;
                    end else if (angle > BACK_LO && angle < BACK_HI) begin
                        flags_next[SEC_BACK]      = 1'b1;
                        last_seen_next[SEC_BACK]  = now_next;
                    end else if (angle > RIGHT_LO && angle < RIGHT_HI) begin
                        flags_next[SEC_RIGHT]     = 1'b1;
                        last_seen_next[SEC_RIGHT] = now_next;
                    end
                end
            end
            ACT_TICK: begin
                // Only the count and the expiry above
            end
            ACT_DONE: begin
                awaiting_next = 1'b0;
                done_next     = 1'b1;
            end
            ACT_STEP: begin
                unique case (mode_reg)
                    MODE_FWD: begin
                        if (flags_aged[SEC_FRONT] || radar) begin
                            cmd       = CMD_STOP;
                            mode_next = MODE_DECIDE;
                        end else begin
                            cmd = CMD_FORWARD;
                        end
                    end
                    MODE_DECIDE: begin
                        priority if (!flags_aged[SEC_LEFT]) begin
                            mode_next = MODE_LEFT;
                        end else if (!flags_aged[SEC_RIGHT]) begin
                            mode_next = MODE_RIGHT;
                        end else begin
                            mode_next = MODE_REV;
                        end
                        flags_next = '0;
                    end
                    MODE_LEFT, MODE_RIGHT, MODE_REV: begin
                        priority if (!awaiting_reg && !done_reg) begin
                            // First phase: issue the manoeuvre
                            awaiting_next = 1'b1;
                            cmd           = man_cmd;
                        end else if (awaiting_reg) begin
                            cmd = CMD_NONE;
                        end else begin
                            // Done seen: clean up and move on
                            flags_next[SEC_FRONT] = 1'b0;
                            done_next             = 1'b0;
                            mode_next             = man_ret;
                        end
                    end
                    default: begin
                        mode_next = MODE_DECIDE;
                    end
                endcase
            end
            default: begin
            end
        endcase

        m_tdata_next = {6'd0, flags_next[SEC_BACK], flags_next[SEC_RIGHT],
                        flags_next[SEC_LEFT], flags_next[SEC_FRONT],
                        mode_next, cmd};
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dist_reg <= MIN_DIST_RST;
            max_dist_reg <= MAX_DIST_RST;
            timeout_reg  <= TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MIN_DIST: min_dist_reg <= cfg_data;
                CFG_MAX_DIST: max_dist_reg <= cfg_data;
                CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                default: begin
                    // Drop writes to unused indexes
                end
            endcase
        end
    end

    // Tracking state and FSM register: advance on every input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg      <= '0;
            flags_reg    <= '0;
            mode_reg     <= MODE_FWD;
            awaiting_reg <= 1'b0;
            done_reg     <= 1'b0;
            for (int i = 0; i < NUM_SEC; i++) begin
                last_seen_reg[i] <= '0;
            end
        end else if (in_xfer) begin
            now_reg      <= now_next;
            flags_reg    <= flags_next;
            mode_reg     <= mode_next;
            awaiting_reg <= awaiting_next;
            done_reg     <= done_next;
            for (int i = 0; i < NUM_SEC; i++) begin
                last_seen_reg[i] <= last_seen_next[i];
            end
        end
    end

    // Output register: load on input transfer, clear once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

// ===== src/lzoa_checker.sv =====
// Port-level checker for the lidar zone obstacle avoider, bound to the top.
// Depends on lzoa_pkg and lidar_zone_obstacle_avoider.
`timescale 1ns / 1ps

module lzoa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lzoa_pkg::M_TDATA_W-1:0]  m_tdata
);

    import lzoa_pkg::*;

    // Every input transfer shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input transfer without a result");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // A stop always leaves the machine deciding
    a_stop_decides: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == CMD_STOP |-> m_tdata[5:3] == MODE_DECIDE)
        else $error("stop without decide state");

    // Driving forward means forward state with a clear front
    a_fwd_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == CMD_FORWARD |->
            m_tdata[5:3] == MODE_FWD && !m_tdata[6])
        else $error("forward with front blocked or wrong state");

endmodule

bind lidar_zone_obstacle_avoider lzoa_checker u_lzoa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/testbench.sv =====
// Self-checking bench for lidar_zone_obstacle_avoider: streams points, ticks,
// done messages and control steps, and predicts every result word in-bench.
// Depends on lzoa_pkg and the block's top level; nothing else.
`timescale 1ns / 1ps

module testbench;
    import lzoa_pkg::*;

    // Index 3 is not a register; the block must drop writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    // tdata: angle_tenths[11:0], distance_mm[27:12], radar_hit[28], zero pad
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    // tuser: action[1:0]
    logic [S_TUSER_W-1:0]    s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    // tdata: command[2:0], nav_state[5:3], front[6], left[7], right[8], back[9]
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    lidar_zone_obstacle_avoider u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the avoider: configuration and state.
    logic [15:0]       min_mm     = MIN_DIST_RST;
    logic [15:0]       max_mm     = MAX_DIST_RST;
    logic [15:0]       timeout_ms = TIMEOUT_RST;
    logic [31:0]       now_ms     = '0;
    logic [31:0]       seen_at [NUM_SEC];
    logic [NUM_SEC-1:0] blocked   = '0;
    mode_t             nav        = MODE_FWD;
    logic              awaiting   = 1'b0;
    logic              done_pending = 1'b0;

    logic [M_TDATA_W-1:0] expected_status [$];
    int unsigned          error_count = 0;
    bit                   idle_on     = 1'b1;

    initial begin
        for (int i = 0; i < NUM_SEC; i++) seen_at[i] = '0;
    end

    // One phase of a turn or reverse: command, wait for done, then clean up.
    task automatic step_manoeuvre(input cmd_t issue, input mode_t next, output cmd_t cmd);
        cmd = CMD_NONE;
        if (!awaiting && !done_pending) begin
            awaiting = 1'b1;
            cmd      = issue;
        end else if (!awaiting) begin
            blocked[SEC_FRONT] = 1'b0;
            done_pending       = 1'b0;
            nav                = next;
        end
    endtask

    // Advance the shadow avoider by one item and queue the status it reports.
    task automatic advance_avoider(input action_t act, input logic [11:0] ang,
                                   input logic [15:0] dist_mm, input logic radar);
        cmd_t        cmd;
        int          sec;
        logic [31:0] age;
        cmd = CMD_NONE;
        sec = -1;
        if (act == ACT_TICK) now_ms = now_ms + 32'd1;
        // Expire stale sectors before the item takes effect.
        for (int i = 0; i < NUM_SEC; i++) begin
            age = now_ms - seen_at[i];
            if (age > {16'd0, timeout_ms}) blocked[i] = 1'b0;
        end
        case (act)
            ACT_POINT: begin
                if (dist_mm >= min_mm && dist_mm <= max_mm) begin
                    if (ang > FRONT_HI || ang < FRONT_LO)      sec = SEC_FRONT;
                    else if (ang > LEFT_LO && ang < LEFT_HI)   sec = SEC_LEFT;
                    else if (ang > BACK_LO && ang < BACK_HI)   sec = SEC_BACK;
                    else if (ang > RIGHT_LO && ang < RIGHT_HI) sec = SEC_RIGHT;
                end
                if (sec >= 0) begin
                    blocked[sec] = 1'b1;
                    seen_at[sec] = now_ms;
                end
            end
            ACT_DONE: begin
                awaiting     = 1'b0;
                done_pending = 1'b1;
            end
            ACT_STEP: begin
                case (nav)
                    MODE_FWD: begin
                        if (blocked[SEC_FRONT] || radar) begin
                            cmd = CMD_STOP;
                            nav = MODE_DECIDE;
                        end else begin
                            cmd = CMD_FORWARD;
                        end
                    end
                    MODE_DECIDE: begin
                        if (!blocked[SEC_LEFT])       nav = MODE_LEFT;
                        else if (!blocked[SEC_RIGHT]) nav = MODE_RIGHT;
                        else                          nav = MODE_REV;
                        blocked = '0;
                    end
                    MODE_LEFT:  step_manoeuvre(CMD_LEFT, MODE_FWD, cmd);
                    MODE_RIGHT: step_manoeuvre(CMD_RIGHT, MODE_FWD, cmd);
                    MODE_REV:   step_manoeuvre(CMD_REVERSE, MODE_DECIDE, cmd);
                    default:    nav = MODE_DECIDE;
                endcase
            end
            default: ;
        endcase
        expected_status.push_back({6'd0, blocked[SEC_BACK], blocked[SEC_RIGHT],
                                   blocked[SEC_LEFT], blocked[SEC_FRONT], nav, cmd});
    endtask

    // Present one item, hold it until the transfer, then maybe leave a gap.
    // Called at a rising edge; returns at a rising edge.
    task automatic send_item(input action_t act, input logic [11:0] ang,
                             input logic [15:0] dist_mm, input logic radar);
        bit took;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'd0, radar, dist_mm, ang};
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        advance_avoider(act, ang, dist_mm, radar);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Drop valid and let every pending result drain out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        bit took;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_DIST: min_mm     = value;
            CFG_MAX_DIST: max_mm     = value;
            CFG_TIMEOUT:  timeout_ms = value;
            default: ;
        endcase
    endtask

    task automatic set_window(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] tmo);
        write_reg(CFG_MIN_DIST, lo);
        write_reg(CFG_MAX_DIST, hi);
        write_reg(CFG_TIMEOUT, tmo);
    endtask

    // Result side: stall in random bursts while idling is enabled.
    int unsigned rx_hold = 0;
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_hold  <= $urandom_range(1, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Sample between edges so the transfer decision is race free.
    logic                 rx_take;
    logic [M_TDATA_W-1:0] rx_word;
    logic [M_TDATA_W-1:0] rx_want;
    always begin
        @(negedge aclk);
        rx_take = aresetn && m_tvalid && m_tready;
        rx_word = m_tdata;
        @(posedge aclk);
        if (rx_take) begin
            if (expected_status.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result %h with nothing pending", rx_word);
            end else begin
                rx_want = expected_status.pop_front();
                if (rx_word !== rx_want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("status mismatch: expected %h, got %h", rx_want, rx_word);
                end
            end
        end
    end

    // Reset window and sector edges, then a full avoidance cycle through
    // reverse, left and right, including a done that arrives early.
    task automatic test_sectors_and_fsm();
        send_item(ACT_POINT, 12'd0,    16'd100,   1'b0);  // front, window low edge
        send_item(ACT_POINT, 12'd3451, 16'd400,   1'b0);  // front, window high edge
        send_item(ACT_POINT, 12'd150,  16'd200,   1'b0);  // on the bound: no sector
        send_item(ACT_POINT, 12'd4095, 16'd300,   1'b0);  // angle past 3599 counts as front
        send_item(ACT_POINT, 12'd751,  16'd99,    1'b0);  // just under window
        send_item(ACT_POINT, 12'd1049, 16'd401,   1'b0);  // just over window
        send_item(ACT_POINT, 12'd751,  16'd101,   1'b0);  // left
        send_item(ACT_POINT, 12'd2849, 16'd300,   1'b0);  // right
        send_item(ACT_POINT, 12'd1651, 16'd300,   1'b0);  // back
        send_item(ACT_POINT, 12'd1950, 16'd65535, 1'b1);  // nothing
        send_item(ACT_TICK,  12'd0,    16'd0,     1'b0);
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // front blocked: stop
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // both sides: reverse
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // issue reverse
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // still waiting
        send_item(ACT_DONE,  12'd0,    16'd0,     1'b0);
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // clean up into decide
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // left clear: turn left
        send_item(ACT_DONE,  12'd0,    16'd0,     1'b0);  // done ahead of the command
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // straight to clean up
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // forward
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b1);  // radar: stop
        send_item(ACT_POINT, 12'd760,  16'd200,   1'b0);  // left
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // left blocked: turn right
        send_item(ACT_STEP,  12'd0,    16'd0,     1'b0);  // issue right
    endtask

    // Full-range window with zero timeout, then an empty window.
    task automatic test_window_limits();
        set_window(16'd0, 16'd65535, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_item(ACT_POINT, 12'd0,    16'd0,     1'b0);
        send_item(ACT_POINT, 12'd900,  16'd65535, 1'b0);
        send_item(ACT_TICK,  12'd0,    16'd0,     1'b0);
        send_item(ACT_POINT, 12'd2000, 16'd0,     1'b0);  // zero timeout: flags drop
        set_window(16'd65535, 16'd0, 16'd65535);
        send_item(ACT_POINT, 12'd0,    16'd0,     1'b0);
        send_item(ACT_POINT, 12'd900,  16'd65535, 1'b0);
        send_item(ACT_POINT, 12'd2700, 16'd300,   1'b0);
    endtask

    // Random items aimed at the sectors and their bounds, with a mix of
    // actions that keeps the state machine cycling through its manoeuvres.
    task automatic send_random_item();
        int unsigned pick;
        action_t     act;
        logic [11:0] base;
        logic [11:0] ang;
        logic [15:0] dist_mm;
        pick = $urandom_range(0, 99);
        if (pick < 45)      act = ACT_POINT;
        else if (pick < 60) act = ACT_TICK;
        else if (pick < 85) act = ACT_STEP;
        else                act = ACT_DONE;
        case ($urandom_range(0, 3))
            0:       base = 12'd0;
            1:       base = 12'd900;
            2:       base = 12'd1800;
            default: base = 12'd2700;
        endcase
        // Centered on a sector, 160 tenths either way; wraps modulo 4096.
        if ($urandom_range(0, 9) < 7) ang = 12'(base + 12'd3936 + 12'($urandom_range(0, 320)));
        else                          ang = 12'($urandom_range(0, 4095));
        case ($urandom_range(0, 9))
            0:       dist_mm = min_mm;
            1:       dist_mm = max_mm;
            2, 3, 4, 5: dist_mm = 16'($urandom_range(min_mm, max_mm));
            default: dist_mm = 16'($urandom_range(0, 65535));
        endcase
        send_item(act, ang, dist_mm, $urandom_range(0, 4) == 0);
    endtask

    task automatic run_phase(input int n_items, input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] tmo, input bit idle);
        set_window(lo, hi, tmo);
        idle_on = idle;
        repeat (n_items) send_random_item();
    endtask

    task automatic test_random_traffic();
        logic [15:0] lo;
        run_phase(150, 16'd0, 16'd65535, 16'd65535, 1'b1);
        run_phase(100, 16'd65535, 16'd0, 16'd0, 1'b1);
        for (int p = 0; p < 5; p++) begin
            lo = 16'($urandom_range(0, 500));
            run_phase(200, lo, lo + 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 40)),
                      p != 3);
        end
        // Closing stretch at full rate with the reset window.
        run_phase(200, MIN_DIST_RST, MAX_DIST_RST, TIMEOUT_RST, 1'b0);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sectors_and_fsm();
        test_window_limits();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge aclk);
        if (error_count == 0 && expected_status.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
